// ===== hdl/uf_pkg.sv =====
// Shared types and constants of the disjoint-set engine.
// Used by the channel interfaces and by the top level; no dependencies.

package uf_pkg;

	localparam int NodeW = 10;	// width of a node index on the channels
	localparam int SizeW = 11;	// width of a set size on the result channel

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RED,
		ST_WALK_RD,
		ST_WALK,
		ST_COMP,
		ST_NEXT,
		ST_CNT_A,
		ST_CNT_B,
		ST_CNT_C,
		ST_OUT
	} uf_state_t;

endpackage

// ===== hdl/uf_if.sv =====
// Valid/ready channel interfaces of the disjoint-set engine: requests and results.
// Depends on uf_pkg for the field widths.

interface uf_req_if import uf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NodeW-1:0] node_first;
	logic [NodeW-1:0] node_second;

	modport source (output valid, node_first, node_second, input ready);
	modport sink (input valid, node_first, node_second, output ready);
endinterface

interface uf_rsp_if import uf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             merged;
	logic [NodeW-1:0] set_root;
	logic [SizeW-1:0] set_size;

	modport source (output valid, merged, set_root, set_size, input ready);
	modport sink (input valid, merged, set_root, set_size, output ready);
endinterface

// ===== hdl/uf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module uf_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/union_find_engine.sv =====
// Top level of the disjoint-set engine: union by size with full path compression.
// Depends on uf_pkg, uf_if (uf_req_if, uf_rsp_if) and uf_ram.
//
//  channel  dir  payload                          transaction when
//  req      in   node_first, node_second          req.valid && req.ready
//  rsp      out  merged, set_root, set_size       rsp.valid && rsp.ready
//
// One request at a time. The single read port of the parent memory sets the pace: one link
// per cycle on the walk and one node per cycle on the compression pass, and with NODES
// below 1024 each node index is first reduced modulo NODES. After reset a clearing pass
// fills both memories before the first request is taken. A result waiting in the output
// register does not block the next request from being taken, but the result of that
// request is held in ST_OUT until the output register is free.

module union_find_engine import uf_pkg::*; #(
	parameter int NODES = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	uf_req_if.sink   req,
	uf_rsp_if.source rsp
);

	localparam int IW     = $clog2(NODES);
	localparam int CW     = $clog2(NODES + 1);
	localparam bit NeedRed = NODES < 1024;
	localparam int KMax   = NeedRed ? 10 - $clog2(NODES + 1) : 0;

	uf_state_t state_q, state_d;

	logic [IW-1:0]    clr_q;
	logic [NodeW-1:0] raw_b_q;
	logic [NodeW-1:0] red_q;
	logic [3:0]       red_k_q;
	logic             side_q;
	logic [IW-1:0]    start_q, cur_q, root_q, ra_q, rb_q;
	logic [CW-1:0]    cnt_a_q;

	logic             res_merged_q;
	logic [IW-1:0]    res_root_q;
	logic [CW-1:0]    res_size_q;

	logic             out_valid_q;
	logic             out_merged_q;
	logic [NodeW-1:0] out_root_q;
	logic [SizeW-1:0] out_size_q;

	// parent memory ports
	logic          p_we;
	logic [IW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
	// size memory ports
	logic          c_we;
	logic [IW-1:0] c_waddr, c_raddr;
	logic [CW-1:0] c_wdata, c_rdata;

	logic [NodeW:0]     red_sub;
	logic               red_ge;
	logic [IW+NodeW-1:0] red_ext;
	logic [IW-1:0]      node_idx;
	logic               a_smaller;
	logic [CW:0]        size_sum;
	logic               out_load;
	logic [IW+NodeW-1:0] root_ext;
	logic [CW+SizeW-1:0] size_ext;

	uf_ram #(.WIDTH(IW), .DEPTH(NODES)) u_parent_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	uf_ram #(.WIDTH(CW), .DEPTH(NODES)) u_size_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// restoring reduction of the raw index modulo NODES, one shifted compare a cycle
	assign red_sub  = (NodeW + 1)'(NODES) << red_k_q;
	assign red_ge   = {1'b0, red_q} >= red_sub;
	assign red_ext  = {{IW{1'b0}}, red_q};
	assign node_idx = red_ext[IW-1:0];

	assign a_smaller = cnt_a_q < c_rdata;
	assign size_sum  = {1'b0, cnt_a_q} + {1'b0, c_rdata};
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);

	assign root_ext = {{NodeW{1'b0}}, res_root_q};
	assign size_ext = {{SizeW{1'b0}}, res_size_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == IW'(NODES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) state_d = NeedRed ? ST_RED : ST_WALK_RD;
			end
			ST_RED: begin
				if (red_k_q == 4'd0) state_d = ST_WALK_RD;
			end
			ST_WALK_RD: state_d = ST_WALK;
			ST_WALK: begin
				if (p_rdata == cur_q) state_d = (start_q == cur_q) ? ST_NEXT : ST_COMP;
			end
			ST_COMP: begin
				if (p_rdata == root_q) state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (side_q) state_d = ST_CNT_A;
				else state_d = NeedRed ? ST_RED : ST_WALK_RD;
			end
			ST_CNT_A: state_d = ST_CNT_B;
			ST_CNT_B: state_d = ST_CNT_C;
			ST_CNT_C: state_d = ST_OUT;
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory ports and handshake
	always_comb begin
		req.ready = 1'b0;
		p_we      = 1'b0;
		p_waddr   = cur_q;
		p_wdata   = root_q;
		p_raddr   = cur_q;
		c_we      = 1'b0;
		c_waddr   = ra_q;
		c_wdata   = size_sum[CW-1:0];
		c_raddr   = ra_q;
		unique case (state_q)
			ST_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = clr_q;
				c_we    = 1'b1;
				c_waddr = clr_q;
				c_wdata = CW'(1);
			end
			ST_IDLE: req.ready = 1'b1;
			ST_WALK_RD: p_raddr = node_idx;
			ST_WALK: begin
				if (p_rdata == cur_q) p_raddr = start_q;
				else p_raddr = p_rdata;
			end
			ST_COMP: begin
				p_we    = 1'b1;
				p_raddr = p_rdata;
			end
			ST_CNT_A: c_raddr = ra_q;
			ST_CNT_B: c_raddr = rb_q;
			ST_CNT_C: begin
				if (ra_q != rb_q) begin
					p_we = 1'b1;
					c_we = 1'b1;
					// hang the smaller root under the larger; a tie keeps the first root
					if (a_smaller) begin
						p_waddr = ra_q;
						p_wdata = rb_q;
						c_waddr = rb_q;
					end else begin
						p_waddr = rb_q;
						p_wdata = ra_q;
						c_waddr = ra_q;
					end
				end
			end
			ST_RED, ST_NEXT, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + IW'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				raw_b_q <= req.node_second;
				red_q   <= req.node_first;
				red_k_q <= 4'(KMax);
				side_q  <= 1'b0;
			end
			ST_RED: begin
				if (red_ge) red_q <= red_q - red_sub[NodeW-1:0];
				if (red_k_q != 4'd0) red_k_q <= red_k_q - 4'd1;
			end
			ST_WALK_RD: begin
				start_q <= node_idx;
				cur_q   <= node_idx;
			end
			ST_WALK: begin
				if (p_rdata == cur_q) begin
					root_q <= cur_q;
					cur_q  <= start_q;
				end else begin
					cur_q <= p_rdata;
				end
			end
			ST_COMP: cur_q <= p_rdata;
			ST_NEXT: begin
				if (side_q) begin
					rb_q <= root_q;
				end else begin
					ra_q    <= root_q;
					side_q  <= 1'b1;
					red_q   <= raw_b_q;
					red_k_q <= 4'(KMax);
				end
			end
			ST_CNT_B: cnt_a_q <= c_rdata;
			ST_CNT_C: begin
				if (ra_q == rb_q) begin
					res_merged_q <= 1'b0;
					res_root_q   <= ra_q;
					res_size_q   <= cnt_a_q;
				end else begin
					res_merged_q <= 1'b1;
					res_root_q   <= a_smaller ? rb_q : ra_q;
					res_size_q   <= size_sum[CW-1:0];
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_merged_q <= res_merged_q;
			out_root_q   <= root_ext[NodeW-1:0];
			out_size_q   <= size_ext[SizeW-1:0];
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.merged   = out_merged_q;
	assign rsp.set_root = out_root_q;
	assign rsp.set_size = out_size_q;

endmodule
